// File: design/tpc_pkg.sv
// Shared constants and controller/datapath handshake types for point clustering.
package tpc_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 12;
    localparam int THR_W          = 12;
    localparam int THR_RESET      = 100;
    localparam int MEMBER_W       = 7;

    typedef struct packed {
        logic load;       // store the input point
        logic start;      // arm masks for a new set
        logic rd;         // read point store at idx
        logic seed;       // take idx as cluster seed
        logic seed_ld;    // init sums from read data
        logic latch_j;    // hold candidate point
        logic absorb;     // move candidate into cluster
        logic div_start;  // start centroid division
        logic emit;       // load the output register
        logic clear;      // drop the set
    } tpc_cmd_t;

    typedef struct packed {
        logic unassigned_bit;
        logic member_bit;
        logic near;
        logic div_done;
        logic out_busy;
    } tpc_status_t;

endpackage

// File: design/threshold_point_clustering.sv
// Threshold point clustering: loads a point set, emits one centroid per cluster.
//
// Input channel (s_valid/s_ready): one point per transfer, one per cycle while
// loading. The transfer with s_last_point set closes the set; the input then
// stays stalled until every cluster of the set has been transferred out.
// Points past MAX_POINTS are dropped and m_overflow is set on that set's results.
// Config channel (cfg_valid/cfg_ready): always ready; write distance_threshold
// only while no set is in progress.
// Result channel (m_valid/m_ready): one transfer per cluster, in seed order,
// with m_last_cluster on the final one. A stalled receiver holds the sequencer.
// Sequencing: clustering walks the store with one RAM read port. Each candidate
// test reads the candidate, then scans the store for members, reading each one
// and comparing its distance, and stops at the first member in range; each
// result then runs a serial division and waits for its result transfer.
// Reset: synchronous active-low aresetn empties the store, sets the threshold
// to 100 and drops any pending result.
module threshold_point_clustering #(
    parameter int MAX_POINTS = tpc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = tpc_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tpc_pkg::THR_W-1:0]    cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [COORD_BITS-1:0]        s_point_x,
    input  logic [COORD_BITS-1:0]        s_point_y,
    input  logic                         s_last_point,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [COORD_BITS-1:0]        m_centroid_x,
    output logic [COORD_BITS-1:0]        m_centroid_y,
    output logic [tpc_pkg::MEMBER_W-1:0] m_member_count,
    output logic                         m_last_cluster,
    output logic                         m_overflow
);
    import tpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    tpc_cmd_t         cmd;
    tpc_status_t      status;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] loaded_cnt;
    logic [CNT_W-1:0] rem_cnt;

    assign cfg_ready = 1'b1;

    tpc_controller #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_last_point (s_last_point),
        .status       (status),
        .loaded_cnt   (loaded_cnt),
        .rem_cnt      (rem_cnt),
        .cmd          (cmd),
        .idx          (idx)
    );

    tpc_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .idx            (idx),
        .status         (status),
        .loaded_cnt     (loaded_cnt),
        .rem_cnt        (rem_cnt),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_centroid_x   (m_centroid_x),
        .m_centroid_y   (m_centroid_y),
        .m_member_count (m_member_count),
        .m_last_cluster (m_last_cluster),
        .m_overflow     (m_overflow)
    );

endmodule

// File: design/tpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/tpc_divider.sv
// Restoring divider, one quotient bit per cycle.
module tpc_divider #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/tpc_datapath.sv
// Point store, cluster masks, distance compare, sums and output register.
module tpc_datapath #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tpc_pkg::tpc_cmd_t                  cmd,
    input  logic [$clog2(MAX_POINTS+1)-1:0]    idx,
    output tpc_pkg::tpc_status_t               status,
    output logic [$clog2(MAX_POINTS+1)-1:0]    loaded_cnt,
    output logic [$clog2(MAX_POINTS+1)-1:0]    rem_cnt,
    input  logic                               cfg_valid,
    input  logic [tpc_pkg::THR_W-1:0]          cfg_data,
    input  logic [COORD_BITS-1:0]              s_point_x,
    input  logic [COORD_BITS-1:0]              s_point_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [COORD_BITS-1:0]              m_centroid_x,
    output logic [COORD_BITS-1:0]              m_centroid_y,
    output logic [tpc_pkg::MEMBER_W-1:0]       m_member_count,
    output logic                               m_last_cluster,
    output logic                               m_overflow
);
    import tpc_pkg::*;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SUM_W   = COORD_BITS + CNT_W;
    localparam int LIMIT_W = 2 * THR_W;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = (SQ_W + 1 > LIMIT_W) ? SQ_W + 1 : LIMIT_W;

    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;
    logic [MAX_POINTS-1:0]   unassigned_reg;
    logic [MAX_POINTS-1:0]   member_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [CNT_W-1:0]        members_reg;
    logic [SUM_W-1:0]        sx_reg;
    logic [SUM_W-1:0]        sy_reg;
    logic [COORD_BITS-1:0]   jx_reg;
    logic [COORD_BITS-1:0]   jy_reg;
    logic [SQ_W-1:0]         sqx_reg;
    logic [SQ_W-1:0]         sqy_reg;
    logic [LIMIT_W-1:0]      limit_reg;
    logic                    m_valid_reg;
    logic [COORD_BITS-1:0]   cx_reg;
    logic [COORD_BITS-1:0]   cy_reg;
    logic [MEMBER_W-1:0]     mc_reg;
    logic                    last_reg;
    logic                    movf_reg;

    logic [2*COORD_BITS-1:0] rd_data;
    logic [COORD_BITS-1:0]   rx;
    logic [COORD_BITS-1:0]   ry;
    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [DIST_W-1:0]       dist_sum;
    logic [IDX_W-1:0]        addr;
    logic                    store_en;
    logic [SUM_W-1:0]        qx;
    logic [SUM_W-1:0]        qy;
    logic                    done_x;
    logic                    done_y;

    assign addr     = idx[IDX_W-1:0];
    assign store_en = cmd.load && (cnt_reg < CNT_W'(MAX_POINTS));

    tpc_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_POINTS)) u_store (
        .aclk    (aclk),
        .wr_en   (store_en),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data ({s_point_y, s_point_x}),
        .rd_en   (cmd.rd),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    assign rx = rd_data[COORD_BITS-1:0];
    assign ry = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign dx = (rx > jx_reg) ? rx - jx_reg : jx_reg - rx;
    assign dy = (ry > jy_reg) ? ry - jy_reg : jy_reg - ry;
    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    tpc_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sx_reg),
        .divisor  (members_reg),
        .done     (done_x),
        .quotient (qx)
    );

    tpc_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sy_reg),
        .divisor  (members_reg),
        .done     (done_y),
        .quotient (qy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            unassigned_reg <= '0;
            member_reg     <= '0;
            rem_reg        <= '0;
            limit_reg      <= LIMIT_W'(THR_RESET * THR_RESET);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= LIMIT_W'(cfg_data) * LIMIT_W'(cfg_data);
            end
            if (cmd.load) begin
                if (store_en) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.start) begin
                // mark every loaded entry as unassigned
                unassigned_reg <= ~({MAX_POINTS{1'b1}} << cnt_reg);
                member_reg     <= '0;
                rem_reg        <= cnt_reg;
            end
            if (cmd.seed) begin
                unassigned_reg[addr] <= 1'b0;
                member_reg           <= MAX_POINTS'(1) << addr;
                rem_reg              <= rem_reg - 1'b1;
            end
            if (cmd.absorb) begin
                unassigned_reg[addr] <= 1'b0;
                member_reg[addr]     <= 1'b1;
                rem_reg              <= rem_reg - 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.clear) begin
                cnt_reg        <= '0;
                ovf_reg        <= 1'b0;
                unassigned_reg <= '0;
                member_reg     <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sqx_reg <= dx * dx;
        sqy_reg <= dy * dy;
        if (cmd.seed_ld) begin
            sx_reg      <= SUM_W'(rx);
            sy_reg      <= SUM_W'(ry);
            members_reg <= CNT_W'(1);
        end
        if (cmd.latch_j) begin
            jx_reg <= rx;
            jy_reg <= ry;
        end
        if (cmd.absorb) begin
            sx_reg      <= sx_reg + SUM_W'(jx_reg);
            sy_reg      <= sy_reg + SUM_W'(jy_reg);
            members_reg <= members_reg + 1'b1;
        end
        if (cmd.emit) begin
            cx_reg   <= qx[COORD_BITS-1:0];
            cy_reg   <= qy[COORD_BITS-1:0];
            mc_reg   <= MEMBER_W'(members_reg);
            last_reg <= rem_reg == '0;
            movf_reg <= ovf_reg;
        end
    end

    assign status.unassigned_bit = unassigned_reg[addr];
    assign status.member_bit     = member_reg[addr];
    assign status.near           = dist_sum < DIST_W'(limit_reg);
    assign status.div_done       = done_x && done_y;
    assign status.out_busy       = m_valid_reg;

    assign loaded_cnt     = cnt_reg;
    assign rem_cnt        = rem_reg;
    assign m_valid        = m_valid_reg;
    assign m_centroid_x   = cx_reg;
    assign m_centroid_y   = cy_reg;
    assign m_member_count = mc_reg;
    assign m_last_cluster = last_reg;
    assign m_overflow     = movf_reg;

endmodule

// File: design/tpc_controller.sv
// Sequencer for loading, seeding, sweeps, division and result transfer.
module tpc_controller #(
    parameter int MAX_POINTS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_last_point,
    input  tpc_pkg::tpc_status_t            status,
    input  logic [$clog2(MAX_POINTS+1)-1:0] loaded_cnt,
    input  logic [$clog2(MAX_POINTS+1)-1:0] rem_cnt,
    output tpc_pkg::tpc_cmd_t               cmd,
    output logic [$clog2(MAX_POINTS+1)-1:0] idx
);
    import tpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        LOAD, START, SEED, SEED_LD, SWEEP, J_CHK, J_LD,
        K_CHK, K_WAIT, K_CMP, DIV, DIV_WAIT, OUT_WAIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [CNT_W-1:0] sweep_reg, sweep_next;

    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        s_next     = s_reg;
        sweep_next = sweep_reg;
        cmd        = '0;
        idx        = j_reg;
        s_ready    = 1'b0;
        case (state_reg)
            LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last_point) begin
                        state_next = START;
                    end
                end
            end
            START: begin
                cmd.start  = 1'b1;
                s_next     = '0;
                state_next = SEED;
            end
            SEED: begin
                idx = s_reg;
                if (status.unassigned_bit) begin
                    cmd.seed   = 1'b1;
                    cmd.rd     = 1'b1;
                    state_next = SEED_LD;
                end else begin
                    s_next = s_reg + 1'b1;
                end
            end
            SEED_LD: begin
                cmd.seed_ld = 1'b1;
                sweep_next  = '0;
                state_next  = SWEEP;
            end
            SWEEP: begin
                if (sweep_reg < rem_cnt) begin
                    j_next     = '0;
                    state_next = J_CHK;
                end else begin
                    state_next = DIV;
                end
            end
            J_CHK: begin
                if (j_reg == loaded_cnt) begin
                    sweep_next = sweep_reg + 1'b1;
                    state_next = SWEEP;
                end else if (status.unassigned_bit) begin
                    cmd.rd     = 1'b1;
                    state_next = J_LD;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            J_LD: begin
                cmd.latch_j = 1'b1;
                k_next      = '0;
                state_next  = K_CHK;
            end
            K_CHK: begin
                idx = k_reg;
                if (k_reg == loaded_cnt) begin
                    j_next     = j_reg + 1'b1;
                    state_next = J_CHK;
                end else if (status.member_bit) begin
                    cmd.rd     = 1'b1;
                    state_next = K_WAIT;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            K_WAIT: begin
                state_next = K_CMP;
            end
            K_CMP: begin
                if (status.near) begin
                    cmd.absorb = 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = J_CHK;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = K_CHK;
                end
            end
            DIV: begin
                cmd.div_start = 1'b1;
                state_next    = DIV_WAIT;
            end
            DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.emit   = 1'b1;
                    state_next = OUT_WAIT;
                end
            end
            OUT_WAIT: begin
                // hold until the result transfer completes
                if (!status.out_busy) begin
                    if (rem_cnt == '0) begin
                        cmd.clear  = 1'b1;
                        state_next = LOAD;
                    end else begin
                        state_next = SEED;
                    end
                end
            end
            default: begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LOAD;
            j_reg     <= '0;
            k_reg     <= '0;
            s_reg     <= '0;
            sweep_reg <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            s_reg     <= s_next;
            sweep_reg <= sweep_next;
        end
    end

endmodule

// File: tb/threshold_point_clustering_tb.sv
// Testbench for threshold_point_clustering: point sets, centroid prediction, result checks.
`timescale 1ns / 1ps

module threshold_point_clustering_tb;
    import tpc_pkg::*;

    localparam int NPTS       = MAX_POINTS_DEF;
    localparam int CB         = COORD_BITS_DEF;
    localparam int IDLE_LIMIT = 4000000;
    localparam int SETTLE     = 200;

    typedef struct {
        logic [CB-1:0]       cx;
        logic [CB-1:0]       cy;
        logic [MEMBER_W-1:0] members;
        logic                last_c;
        logic                ovf;
    } cluster_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [THR_W-1:0]    cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [CB-1:0]       s_point_x = '0;
    logic [CB-1:0]       s_point_y = '0;
    logic                s_last_point = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CB-1:0]       m_centroid_x;
    logic [CB-1:0]       m_centroid_y;
    logic [MEMBER_W-1:0] m_member_count;
    logic                m_last_cluster;
    logic                m_overflow;

    // predictor state
    logic [CB-1:0]    store_x [NPTS];
    logic [CB-1:0]    store_y [NPTS];
    int               loaded = 0;
    bit               dropped = 0;
    logic [THR_W-1:0] join_dist = THR_W'(THR_RESET);

    cluster_t pending_clusters[$];
    int       errors = 0;
    int       points_sent = 0;
    int       sets_sent = 0;
    int       clusters_seen = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       idle_cycles = 0;

    always #4 aclk = ~aclk;

    threshold_point_clustering dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_point_x(s_point_x),
        .s_point_y(s_point_y), .s_last_point(s_last_point),
        .m_valid(m_valid), .m_ready(m_ready), .m_centroid_x(m_centroid_x),
        .m_centroid_y(m_centroid_y), .m_member_count(m_member_count),
        .m_last_cluster(m_last_cluster), .m_overflow(m_overflow)
    );

    function automatic bit near_member(int j, logic [NPTS-1:0] mem, longint lim);
        longint dx, dy;
        for (int k = 0; k < NPTS; k++) begin
            if (mem[k]) begin
                dx = longint'(store_x[k]) - longint'(store_x[j]);
                dy = longint'(store_y[k]) - longint'(store_y[j]);
                if (dx * dx + dy * dy < lim) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Store one point; on the closing point, group the set and queue its centroids.
    task automatic predict_point(logic [CB-1:0] x, logic [CB-1:0] y, logic last_p);
        logic [NPTS-1:0] unassigned, mem;
        longint          lim, sx, sy;
        int              seed, remaining, n, cnt;
        cluster_t        c, found[$];
        if (loaded < NPTS) begin
            store_x[loaded] = x;
            store_y[loaded] = y;
            loaded++;
        end else begin
            dropped = 1'b1;
        end
        if (!last_p) return;
        n = loaded;
        lim = longint'(join_dist) * longint'(join_dist);
        unassigned = '0;
        for (int j = 0; j < n; j++) unassigned[j] = 1'b1;
        while (unassigned != '0) begin
            seed = 0;
            while (!unassigned[seed]) seed++;
            unassigned[seed] = 1'b0;
            mem = '0;
            mem[seed] = 1'b1;
            remaining = $countones(unassigned);
            for (int sw = 0; sw < remaining; sw++) begin
                for (int j = 0; j < n; j++) begin
                    if (unassigned[j] && near_member(j, mem, lim)) begin
                        unassigned[j] = 1'b0;
                        mem[j] = 1'b1;
                    end
                end
                remaining = $countones(unassigned);
            end
            sx = 0; sy = 0;
            cnt = $countones(mem);
            for (int j = 0; j < n; j++) begin
                if (mem[j]) begin
                    sx += store_x[j];
                    sy += store_y[j];
                end
            end
            c.cx = CB'(sx / cnt);
            c.cy = CB'(sy / cnt);
            c.members = MEMBER_W'(cnt);
            c.last_c = 1'b0;
            c.ovf = dropped;
            found.insert(found.size(), c);
        end
        found[found.size()-1].last_c = 1'b1;
        foreach (found[i]) pending_clusters.insert(pending_clusters.size(), found[i]);
        loaded = 0;
        dropped = 1'b0;
        sets_sent++;
    endtask

    task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y, logic last_p);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        s_last_point <= last_p;
        do @(posedge aclk); while (!s_ready);
        predict_point(x, y, last_p);
        points_sent++;
    endtask

    // Wait for the set to drain, then let the sequencer settle before a write.
    task automatic write_threshold(logic [THR_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_clusters.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        join_dist = value;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cluster_t e;
        if (aresetn && m_valid && m_ready) begin
            clusters_seen++;
            if (pending_clusters.size() == 0) begin
                errors++;
                $display("%0t: unexpected cluster x=%0d y=%0d n=%0d", $time,
                         m_centroid_x, m_centroid_y, m_member_count);
            end else begin
                e = pending_clusters.pop_front();
                if (e.cx !== m_centroid_x || e.cy !== m_centroid_y ||
                    e.members !== m_member_count || e.last_c !== m_last_cluster ||
                    e.ovf !== m_overflow) begin
                    errors++;
                    $display("%0t: mismatch expected x=%0d y=%0d n=%0d last=%0b ovf=%0b",
                             $time, e.cx, e.cy, e.members, e.last_c, e.ovf);
                    $display("%0t:          actual   x=%0d y=%0d n=%0d last=%0b ovf=%0b",
                             $time, m_centroid_x, m_centroid_y, m_member_count,
                             m_last_cluster, m_overflow);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on any channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic test_corners();
        send_point(CB'(0), CB'(0), 1'b0);
        send_point(12'hFFF, 12'hFFF, 1'b0);
        send_point(12'hFFF, CB'(0), 1'b0);
        send_point(CB'(0), 12'hFFF, 1'b1);
        send_point(12'hAAA, 12'h555, 1'b1);
        // chain: the middle point joins first, the far one on the next sweep
        write_threshold(THR_W'(101));
        send_point(CB'(0), CB'(0), 1'b0);
        send_point(CB'(200), CB'(0), 1'b0);
        send_point(CB'(100), CB'(0), 1'b0);
        send_point(CB'(3000), CB'(3000), 1'b0);
        send_point(CB'(3000), CB'(3100), 1'b1);
        // a distance equal to the threshold does not join
        write_threshold(THR_W'(1));
        send_point(CB'(7), CB'(7), 1'b0);
        send_point(CB'(7), CB'(8), 1'b0);
        send_point(CB'(7), CB'(7), 1'b1);
    endtask

    task automatic test_zero_threshold();
        write_threshold(THR_W'(0));
        for (int i = 0; i < 6; i++) send_point(CB'(5), CB'(5), 1'b0);
        send_point(CB'(6), CB'(5), 1'b1);
    endtask

    task automatic test_store_full();
        write_threshold(12'hFFF);
        for (int i = 0; i < NPTS; i++)
            send_point(CB'($urandom_range(1500, 2500)), CB'($urandom_range(1500, 2500)), 1'b0);
        // dropped point still closes the set
        send_point(12'hFFF, 12'hFFF, 1'b1);
        for (int i = 0; i < NPTS + 3; i++)
            send_point(CB'($urandom), CB'($urandom), i == NPTS + 2);
    endtask

    task automatic test_random_sets(int npoints);
        int          sz, target;
        logic [CB-1:0] cx [4], cy [4];
        int          k, spread;
        target = points_sent + npoints;
        while (points_sent < target) begin
            case ($urandom_range(5))
                0: write_threshold(THR_W'(0));
                1: write_threshold(12'hFFF);
                2: write_threshold(THR_W'($urandom));
                default: write_threshold(THR_W'($urandom_range(1, 300)));
            endcase
            sz = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
            spread = $urandom_range(1, 400);
            for (int i = 0; i < 4; i++) begin
                cx[i] = CB'($urandom);
                cy[i] = CB'($urandom);
            end
            for (int i = 0; i < sz; i++) begin
                k = $urandom_range(3);
                if ($urandom_range(4) == 0)
                    send_point(CB'($urandom), CB'($urandom), i == sz - 1);
                else
                    send_point(CB'((int'(cx[k]) + $urandom_range(spread)) % 4096),
                               CB'((int'(cy[k]) + $urandom_range(spread)) % 4096),
                               i == sz - 1);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corners();
        test_zero_threshold();
        test_store_full();
        idle_pct = 0;  stall_pct = 0;  test_random_sets(40);
        idle_pct = 88; stall_pct = 0;  test_random_sets(40);
        idle_pct = 0;  stall_pct = 88; test_random_sets(35);
        idle_pct = 7;  stall_pct = 7;  test_random_sets(40);
        s_valid <= 1'b0;
        while (pending_clusters.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        $display("Covered %0d points in %0d sets, %0d clusters checked,", points_sent,
                 sets_sent, clusters_seen);
        $display("with threshold extremes, store overflow and four flow-control phases.");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: threshold_point_clustering.f
design/tpc_pkg.sv
design/tpc_ram.sv
design/tpc_divider.sv
design/tpc_datapath.sv
design/tpc_controller.sv
design/threshold_point_clustering.sv
tb/threshold_point_clustering_tb.sv
